// ===== rtl/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared constants and helpers of the line point generator: queue sizing
// and the width of one queued line description.
// ----------------------------------------------------------------------------
package lpg_pkg;

  // depth of the queue between setup and stepping
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrBits   = $clog2(QueueDepth);

  // one queued line: swapped, minor_down, start, end, minor start,
  // major span, minor span
  function automatic int unsigned lpg_entry_bits(input int unsigned coord_bits);
    return 5 * coord_bits + 2;
  endfunction

endpackage

// ===== rtl/line_point_generator.sv =====
// The first point of a line passes the queue, the stepper's load registers and
// the output register before it can be popped. Points of a line come out one
// per cycle while the consumer pops; each line is loaded, then walked step by step.
// Requests with no major extent are dropped at setup.
// A two-entry queue lets new requests in while the stepper walks a line.
// Reset (rst_ni low, asynchronous) empties the queue and the output register.
// ----------------------------------------------------------------------------
// line_point_generator
// Integer Bresenham rasterizer: one line request in, one point per major
// step out, the final point of each line marked.
// ----------------------------------------------------------------------------
module line_point_generator #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] point_x_o,
  output logic [COORD_BITS-1:0] point_y_o,
  output logic                  last_point_o
);
  import lpg_pkg::*;

  localparam int unsigned EntryBits = lpg_entry_bits(COORD_BITS);

  logic                 q_push, q_full, q_pop, q_valid;
  logic [EntryBits-1:0] q_wdata, q_rdata;

  // front end: classify and order
  lpg_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .push_i    (push),
    .full_o    (full),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  // decoupling queue
  lpg_fifo #(.WIDTH(EntryBits)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // back end: point stepping
  lpg_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .last_point_o (last_point_o)
  );

endmodule

// ===== rtl/lpg_setup.sv =====
// ----------------------------------------------------------------------------
// lpg_setup
// Front end: takes a line request, picks the major axis, orders the
// endpoints, computes spans and writes one line description into the queue.
// Lines with no major extent produce nothing and are dropped here.
// ----------------------------------------------------------------------------
module lpg_setup #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output logic [lpg_pkg::lpg_entry_bits(COORD_BITS)-1:0] q_data_o
);
  import lpg_pkg::*;

  typedef struct packed {
    logic                  swapped;
    logic                  minor_down;
    logic [COORD_BITS-1:0] major_pos;
    logic [COORD_BITS-1:0] major_end;
    logic [COORD_BITS-1:0] minor_pos;
    logic [COORD_BITS-1:0] major_span;
    logic [COORD_BITS-1:0] minor_span;
  } line_t;

  logic [COORD_BITS-1:0] span_x, span_y;
  logic                  steep;
  logic [COORD_BITS-1:0] a1, a2, b1, b2;
  line_t                 line;

  // classify and order endpoints
  always_comb begin
    span_x = (start_x_i > end_x_i) ? start_x_i - end_x_i : end_x_i - start_x_i;
    span_y = (start_y_i > end_y_i) ? start_y_i - end_y_i : end_y_i - start_y_i;
    steep  = span_y > span_x;
    if (steep) begin
      a1 = start_y_i; b1 = start_x_i; a2 = end_y_i; b2 = end_x_i;
    end else begin
      a1 = start_x_i; b1 = start_y_i; a2 = end_x_i; b2 = end_y_i;
    end
    line.swapped = steep;
    if (a1 > a2) begin
      line.major_pos = a2;
      line.major_end = a1;
      line.minor_pos = b2;
      line.minor_down = !(b2 < b1);
      line.major_span = a1 - a2;
    end else begin
      line.major_pos = a1;
      line.major_end = a2;
      line.minor_pos = b1;
      line.minor_down = !(b1 < b2);
      line.major_span = a2 - a1;
    end
    line.minor_span = (b1 > b2) ? b1 - b2 : b2 - b1;
  end

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i && (line.major_span != '0);
  assign q_data_o = line;

endmodule

// ===== rtl/lpg_fifo.sv =====
// ----------------------------------------------------------------------------
// lpg_fifo
// Short register queue that decouples line setup from point stepping.
// ----------------------------------------------------------------------------
module lpg_fifo #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import lpg_pkg::*;

  logic [WIDTH-1:0]    mem_q [QueueDepth];
  logic [QPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrBits:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == (QPtrBits+1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/lpg_stepper.sv =====
// ----------------------------------------------------------------------------
// lpg_stepper
// Back end: loads one queued line and walks it one major step per beat,
// tracking the doubled integer error term; points leave through an output
// register so stepping continues while the consumer pops.
// ----------------------------------------------------------------------------
module lpg_stepper #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  logic [lpg_pkg::lpg_entry_bits(COORD_BITS)-1:0] q_data_i,
  output logic                  q_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [COORD_BITS-1:0] point_x_o,
  output logic [COORD_BITS-1:0] point_y_o,
  output logic                  last_point_o
);
  import lpg_pkg::*;

  localparam int unsigned ErrBits = COORD_BITS + 3;

  typedef struct packed {
    logic                  swapped;
    logic                  minor_down;
    logic [COORD_BITS-1:0] major_pos;
    logic [COORD_BITS-1:0] major_end;
    logic [COORD_BITS-1:0] minor_pos;
    logic [COORD_BITS-1:0] major_span;
    logic [COORD_BITS-1:0] minor_span;
  } line_t;

  line_t                      line;
  logic                       busy_q, out_valid_q;
  logic                       swp_q, down_q;
  logic [COORD_BITS-1:0]      pos_q, end_q, minor_q, majs_q, mins_q;
  logic signed [ErrBits-1:0]  err_q, err_sub, err_add;
  logic [COORD_BITS-1:0]      px_q, py_q, minor_next;
  logic                       last_q;
  logic                       load, emit, moved, is_last;
  logic [COORD_BITS:0]        pos_inc;

  assign line    = q_data_i;
  assign load    = !busy_q && q_valid_i;
  assign q_pop_o = load;
  assign emit    = busy_q && (!out_valid_q || pop_i);

  // error update and minor step
  always_comb begin
    err_sub    = err_q - $signed({2'b00, mins_q, 1'b0});
    err_add    = err_sub + $signed({2'b00, majs_q, 1'b0});
    moved      = err_sub[ErrBits-1];
    minor_next = down_q ? minor_q - COORD_BITS'(1) : minor_q + COORD_BITS'(1);
    pos_inc    = {1'b0, pos_q} + (COORD_BITS+1)'(1);
    is_last    = pos_inc == {1'b0, end_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (emit && is_last) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // line walk and output beat
  always_ff @(posedge clk_i) begin
    if (load) begin
      swp_q   <= line.swapped;
      down_q  <= line.minor_down;
      pos_q   <= line.major_pos;
      end_q   <= line.major_end;
      minor_q <= line.minor_pos;
      majs_q  <= line.major_span;
      mins_q  <= line.minor_span;
      err_q   <= $signed({3'b000, line.major_span});
    end else if (emit) begin
      pos_q <= pos_inc[COORD_BITS-1:0];
      if (moved) begin
        minor_q <= minor_next;
        err_q   <= err_add;
      end else begin
        err_q <= err_sub;
      end
    end
    if (emit) begin
      px_q   <= swp_q ? minor_q : pos_q;
      py_q   <= swp_q ? pos_q : minor_q;
      last_q <= is_last;
    end
  end

  assign empty_o      = !out_valid_q;
  assign point_x_o    = px_q;
  assign point_y_o    = py_q;
  assign last_point_o = last_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: line point generator regression
// Drives line requests through the push/full side and drains points through
// the pop/empty side, with random idle gaps on both. A short table of
// directed lines comes first, then random lines. Every point is checked
// against a behavioral Bresenham tracer in this bench or a typed-in point.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CoordBits  = 6;
  localparam int unsigned RandLines  = 230;
  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned TailCycles = 150;
  localparam int unsigned MaxPrinted = 40;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [CoordBits:0]   span_t;

  // how a row's points are known: traced, typed in, or none at all
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_POINTS,
    ROW_ONE_POINT
  } row_kind_e;

  typedef struct {
    int        sx;
    int        sy;
    int        ex;
    int        ey;
    row_kind_e kind;
    int        px;
    int        py;
  } line_row_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } point_t;

  logic   clk_i        = 1'b0;
  logic   rst_ni       = 1'b0;
  logic   push         = 1'b0;
  logic   pop          = 1'b0;
  coord_t start_x_i    = '0;
  coord_t start_y_i    = '0;
  coord_t end_x_i      = '0;
  coord_t end_y_i      = '0;
  logic   full;
  logic   empty;
  coord_t point_x_o;
  coord_t point_y_o;
  logic   last_point_o;

  line_row_t line_plan[$];
  point_t    pending_points[$];
  line_row_t directed_rows[$];
  int        err_count  = 0;
  int        pop_hold   = 0;
  int        cycle_cnt  = 0;
  logic      calm       = 1'b0;

  line_point_generator #(
    .COORD_BITS(CoordBits)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .empty       (empty),
    .pop         (pop),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .last_point_o(last_point_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
  endtask

  function automatic span_t coord_span(input coord_t a, input coord_t b);
    return (a > b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, b} - {1'b0, a});
  endfunction

  // Bresenham tracer: queues every point the block owes for one line
  function automatic void trace_line(input coord_t sx, input coord_t sy,
                                     input coord_t ex, input coord_t ey);
    logic              steep;
    logic              down;
    coord_t            a1, b1, a2, b2, tmp, minor;
    span_t             dmaj, dmin, pos;
    logic signed [8:0] err;
    point_t            pt;
    steep = coord_span(sy, ey) > coord_span(sx, ex);
    if (steep) begin
      a1 = sy; b1 = sx; a2 = ey; b2 = ex;
    end else begin
      a1 = sx; b1 = sy; a2 = ex; b2 = ey;
    end
    // order so the major coordinate rises
    if (a1 > a2) begin
      tmp = a1; a1 = a2; a2 = tmp;
      tmp = b1; b1 = b2; b2 = tmp;
    end
    dmaj  = {1'b0, a2} - {1'b0, a1};
    dmin  = coord_span(b1, b2);
    down  = !(b1 < b2);
    minor = b1;
    err   = $signed({2'b00, dmaj});
    for (pos = {1'b0, a1}; pos < {1'b0, a2}; pos = pos + span_t'(1)) begin
      pt.x    = steep ? minor : pos[CoordBits-1:0];
      pt.y    = steep ? pos[CoordBits-1:0] : minor;
      pt.last = (pos + span_t'(1)) == {1'b0, a2};
      pending_points.insert(pending_points.size(), pt);
      err = err - $signed({1'b0, dmin, 1'b0});
      if (err < 0) begin
        minor = down ? minor - coord_t'(1) : minor + coord_t'(1);
        err   = err + $signed({1'b0, dmaj, 1'b0});
      end
    end
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // quiet stretches with no idling on either side
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 300 == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  // result side: pop with random stalls
  always @(posedge clk_i) begin
    if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 99) < 25) begin
        pop_hold <= pick_gap();
      end
    end
  end

  // monitor: queue expectations on request beats, check point beats
  always @(posedge clk_i) begin
    line_row_t row;
    point_t    want;
    if (rst_ni) begin
      if (push && !full) begin
        if (line_plan.size() == 0) begin
          report_mismatch("request beat with no line planned");
        end else begin
          row = line_plan.pop_front();
          case (row.kind)
            ROW_PREDICT: begin
              trace_line(start_x_i, start_y_i, end_x_i, end_y_i);
            end
            ROW_ONE_POINT: begin
              want.x    = coord_t'(row.px);
              want.y    = coord_t'(row.py);
              want.last = 1'b1;
              pending_points.insert(pending_points.size(), want);
            end
            default: begin
            end
          endcase
        end
      end
      if (pop && !empty) begin
        if (pending_points.size() == 0) begin
          report_mismatch($sformatf("unexpected point (%0d,%0d) last=%0b",
                                    point_x_o, point_y_o, last_point_o));
        end else begin
          want = pending_points.pop_front();
          if (point_x_o !== want.x) begin
            report_mismatch($sformatf("point_x %0d, want %0d", point_x_o, want.x));
          end
          if (point_y_o !== want.y) begin
            report_mismatch($sformatf("point_y %0d, want %0d", point_y_o, want.y));
          end
          if (last_point_o !== want.last) begin
            report_mismatch($sformatf("last_point %0b, want %0b",
                                      last_point_o, want.last));
          end
        end
      end
    end
  end

  // watchdog: ends the run when no beat moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("line_point_generator regression: fail");
    $finish;
  end

  // one request beat, after a random idle gap
  task automatic send_line(input line_row_t row);
    int gap;
    gap = pick_gap();
    line_plan.insert(line_plan.size(), row);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    start_x_i <= coord_t'(row.sx);
    start_y_i <= coord_t'(row.sy);
    end_x_i   <= coord_t'(row.ex);
    end_y_i   <= coord_t'(row.ey);
    do @(posedge clk_i); while (full);
  endtask

  // random line: mostly arbitrary, some short, some on the corners
  function automatic line_row_t random_line();
    line_row_t row;
    int        r;
    r        = $urandom_range(0, 99);
    row.kind = ROW_PREDICT;
    row.px   = 0;
    row.py   = 0;
    row.sx   = $urandom_range(0, 63);
    row.sy   = $urandom_range(0, 63);
    if (r < 55) begin
      row.ex = $urandom_range(0, 63);
      row.ey = $urandom_range(0, 63);
    end else if (r < 85) begin
      row.ex = (row.sx + $urandom_range(0, 8) + 60) % 64;
      row.ey = (row.sy + $urandom_range(0, 8) + 60) % 64;
    end else if (r < 92) begin
      row.ex = row.sx;
      row.ey = row.sy;
    end else begin
      row.sx = $urandom_range(0, 1) * 63;
      row.sy = $urandom_range(0, 1) * 63;
      row.ex = $urandom_range(0, 1) * 63;
      row.ey = $urandom_range(0, 63);
    end
    return row;
  endfunction

  // main sequence
  initial begin
    line_row_t row;
    directed_rows = '{
      // identical endpoints: nothing comes out
      '{0, 0, 0, 0, ROW_NO_POINTS, 0, 0},
      '{63, 63, 63, 63, ROW_NO_POINTS, 0, 0},
      '{5, 10, 5, 10, ROW_NO_POINTS, 0, 0},
      // one-step lines, shallow and steep, either order
      '{0, 0, 1, 0, ROW_ONE_POINT, 0, 0},
      '{63, 63, 62, 63, ROW_ONE_POINT, 62, 63},
      '{0, 63, 1, 62, ROW_ONE_POINT, 0, 63},
      '{0, 0, 0, 1, ROW_ONE_POINT, 0, 0},
      '{63, 1, 63, 0, ROW_ONE_POINT, 63, 0},
      // full-length diagonals (equal spans stay x major)
      '{0, 0, 63, 63, ROW_PREDICT, 0, 0},
      '{63, 63, 0, 0, ROW_PREDICT, 0, 0},
      '{63, 0, 0, 63, ROW_PREDICT, 0, 0},
      '{0, 63, 63, 0, ROW_PREDICT, 0, 0},
      // axis lines: minor coordinate never moves
      '{0, 0, 63, 0, ROW_PREDICT, 0, 0},
      '{0, 0, 0, 63, ROW_PREDICT, 0, 0},
      '{10, 10, 50, 10, ROW_PREDICT, 0, 0},
      '{10, 10, 10, 50, ROW_PREDICT, 0, 0},
      // general slopes both ways
      '{10, 5, 40, 20, ROW_PREDICT, 0, 0},
      '{40, 20, 10, 5, ROW_PREDICT, 0, 0},
      '{5, 10, 20, 40, ROW_PREDICT, 0, 0},
      '{20, 40, 5, 10, ROW_PREDICT, 0, 0},
      '{0, 0, 63, 1, ROW_PREDICT, 0, 0},
      '{63, 1, 0, 0, ROW_PREDICT, 0, 0},
      '{32, 0, 31, 63, ROW_PREDICT, 0, 0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_line(directed_rows[i]);
    end

    repeat (RandLines) begin
      row = random_line();
      send_line(row);
    end
    push <= 1'b0;

    while (pending_points.size() != 0 || line_plan.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_points.size() != 0) begin
      report_mismatch($sformatf("%0d points never came out", pending_points.size()));
    end

    if (err_count == 0) begin
      $display("line_point_generator regression: pass");
    end else begin
      $display("line_point_generator regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lpg_pkg.sv
rtl/lpg_setup.sv
rtl/lpg_fifo.sv
rtl/lpg_stepper.sv
rtl/line_point_generator.sv
bench/tb_top.sv
